>>> sv/btex_pkg.sv
package btex_pkg;

  localparam int STORE_ELEMENTS = 16384;
  localparam int MEM_AW         = $clog2(STORE_ELEMENTS);

  localparam int DIM_W    = 13;
  localparam int STRIDE_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int ADDR_W   = 14;
  localparam int VAL_W    = 16;
  localparam int COORD_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE     = 2'd2;

  localparam logic [DIM_W-1:0]    TEX_WIDTH_RST  = 13'd64;
  localparam logic [DIM_W-1:0]    TEX_HEIGHT_RST = 13'd64;
  localparam logic [STRIDE_W-1:0] STRIDE_RST     = 3'd3;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // fetch/lerp schedule: one step per cycle, reads on steps 0..11
  localparam logic [3:0] FETCH_READS = 4'd12;
  localparam logic [3:0] FETCH_LAST  = 4'd13;
  localparam logic [1:0] TEX_LAST    = 2'd3;
  localparam logic [1:0] PH_TOP      = 2'd2;
  localparam logic [1:0] PH_BOT      = 2'd0;
  localparam logic [1:0] PH_FIN      = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PX,
    ST_PY,
    ST_ROW0,
    ST_ROW1,
    ST_TEX,
    ST_FETCH,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PX,
    OP_PY,
    OP_ROW0,
    OP_ROW1,
    OP_TEX,
    OP_TOP,
    OP_BOT,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] sel;
    logic       rd_en;
    logic [1:0] rd_ch;
    logic [1:0] rd_k;
    logic       latch;
    logic       mem_we;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

>>> sv/btex_req_if.sv
interface btex_req_if;
  import btex_pkg::*;
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [ADDR_W-1:0]   elem_addr;
  logic [VAL_W-1:0]    elem_value;
  logic [COORD_W-1:0]  coord_u;
  logic [COORD_W-1:0]  coord_v;

  modport source (output valid, req_type, elem_addr, elem_value, coord_u, coord_v,
                  input ready);
  modport sink   (input valid, req_type, elem_addr, elem_value, coord_u, coord_v,
                  output ready);
endinterface

>>> sv/btex_res_if.sv
interface btex_res_if;
  import btex_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] out_red;
  logic [VAL_W-1:0] out_green;
  logic [VAL_W-1:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

>>> sv/btex_cfg_if.sv
interface btex_cfg_if;
  import btex_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

>>> sv/btex_ctrl.sv
module btex_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_type,
  output logic              in_ready,
  input  btex_pkg::status_t status,
  output btex_pkg::cmd_t    cmd
);
  import btex_pkg::*;

  state_t     state, state_next;
  logic [3:0] cnt, cnt_next;
  logic       accept;
  logic [1:0] ph;
  logic [1:0] ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign ph       = cnt[1:0];
  assign ch       = cnt[3:2];

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.rd_ch    = ch;
    cmd.rd_k     = ph;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_type == REQ_SAMPLE) begin
            cmd.latch  = 1'b1;
            state_next = ST_PX;
          end else begin
            cmd.mem_we = 1'b1;
          end
        end
      end
      ST_PX: begin
        cmd.op     = OP_PX;
        state_next = ST_PY;
      end
      ST_PY: begin
        cmd.op     = OP_PY;
        state_next = ST_ROW0;
      end
      ST_ROW0: begin
        cmd.op     = OP_ROW0;
        state_next = ST_ROW1;
      end
      ST_ROW1: begin
        cmd.op     = OP_ROW1;
        cnt_next   = '0;
        state_next = ST_TEX;
      end
      ST_TEX: begin
        cmd.op  = OP_TEX;
        cmd.sel = ph;
        if (ph == TEX_LAST) begin
          cnt_next   = '0;
          state_next = ST_FETCH;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      ST_FETCH: begin
        // four reads per channel; lerps of a channel trail its reads
        cmd.rd_en = (cnt < FETCH_READS);
        if (ph == PH_TOP && cnt < FETCH_READS) begin
          cmd.op  = OP_TOP;
          cmd.sel = ch;
        end else if (ph == PH_BOT && ch != 2'd0) begin
          cmd.op  = OP_BOT;
          cmd.sel = ch - 2'd1;
        end else if (ph == PH_FIN && ch != 2'd0) begin
          cmd.op  = OP_FIN;
          cmd.sel = ch - 2'd1;
        end
        if (cnt == FETCH_LAST) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/btex_dp.sv
module btex_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  btex_pkg::cmd_t                cmd,
  output btex_pkg::status_t             status,
  input  logic [btex_pkg::ADDR_W-1:0]   elem_addr,
  input  logic [btex_pkg::VAL_W-1:0]    elem_value,
  input  logic [btex_pkg::COORD_W-1:0]  coord_u,
  input  logic [btex_pkg::COORD_W-1:0]  coord_v,
  btex_cfg_if.sink                      cfg,
  btex_res_if.source                    res
);
  import btex_pkg::*;

  // configuration
  logic [DIM_W-1:0]    tex_width, tex_height;
  logic [STRIDE_W-1:0] stride;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= TEX_WIDTH_RST;
      tex_height <= TEX_HEIGHT_RST;
      stride     <= STRIDE_RST;
    end else if (cfg.valid) begin
      case (cfg.addr)
        CFG_TEX_WIDTH:  tex_width  <= cfg.data[DIM_W-1:0];
        CFG_TEX_HEIGHT: tex_height <= cfg.data[DIM_W-1:0];
        CFG_STRIDE:     stride     <= cfg.data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] w_eff, h_eff;
  assign w_eff = (tex_width  == '0) ? DIM_W'(1) : tex_width;
  assign h_eff = (tex_height == '0) ? DIM_W'(1) : tex_height;

  // sample state
  logic [COORD_W-1:0] u_r, v_r;
  logic [29:0]        px_r, py_r;
  logic [25:0]        rb0, rb1;
  logic [28:0]        ta [4];
  logic [VAL_W-1:0]   tq [4];
  logic [VAL_W-1:0]   top_r, bot_r;
  logic [VAL_W-1:0]   rgb [3];

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      u_r <= coord_u;
      v_r <= coord_v;
    end
  end

  // corner, weights and clamped indices
  logic [13:0]      x1, y1, xm, ym;
  logic [15:0]      wr, wb;
  logic [DIM_W-1:0] c0, c1, r0, r1;

  assign x1 = px_r[29:16];
  assign y1 = py_r[29:16];
  assign wr = px_r[15:0];
  assign wb = py_r[15:0];
  assign xm = x1 - 14'd1;
  assign ym = y1 - 14'd1;

  always_comb begin
    c1 = (x1 >= {1'b0, w_eff}) ? w_eff - DIM_W'(1) : x1[DIM_W-1:0];
    r1 = (y1 >= {1'b0, h_eff}) ? h_eff - DIM_W'(1) : y1[DIM_W-1:0];
    if (x1 == '0)                 c0 = '0;
    else if (xm >= {1'b0, w_eff}) c0 = w_eff - DIM_W'(1);
    else                          c0 = xm[DIM_W-1:0];
    if (y1 == '0)                 r0 = '0;
    else if (ym >= {1'b0, h_eff}) r0 = h_eff - DIM_W'(1);
    else                          r0 = ym[DIM_W-1:0];
  end

  // shared multiplier
  logic signed [27:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [45:0] mul_p;
  logic [VAL_W-1:0]   lo, hi;
  logic [15:0]        wgt;
  logic signed [16:0] diff;
  logic [16:0]        vflip;
  logic [25:0]        tex_base;
  logic signed [45:0] lerp_sum;
  logic [17:0]        lerp_val;

  assign vflip    = 17'h10000 - {1'b0, v_r};
  assign tex_base = (cmd.sel[1] ? rb1 : rb0) + {13'd0, (cmd.sel[0] ? c1 : c0)};

  always_comb begin
    lo  = top_r;
    hi  = bot_r;
    wgt = wb;
    case (cmd.op)
      OP_TOP: begin
        lo  = tq[0];
        hi  = tq[1];
        wgt = wr;
      end
      OP_BOT: begin
        lo  = tq[2];
        hi  = tq[3];
        wgt = wr;
      end
      default: ;
    endcase
  end

  assign diff = $signed({1'b0, hi}) - $signed({1'b0, lo});

  always_comb begin
    case (cmd.op)
      OP_PX: begin
        mul_a = {15'd0, w_eff};
        mul_b = {2'd0, u_r};
      end
      OP_PY: begin
        mul_a = {15'd0, h_eff};
        mul_b = {1'b0, vflip};
      end
      OP_ROW0: begin
        mul_a = {15'd0, r0};
        mul_b = {5'd0, w_eff};
      end
      OP_ROW1: begin
        mul_a = {15'd0, r1};
        mul_b = {5'd0, w_eff};
      end
      OP_TEX: begin
        mul_a = {2'd0, tex_base};
        mul_b = {15'd0, stride};
      end
      default: begin
        mul_a = {{11{diff[16]}}, diff};
        mul_b = {2'd0, wgt};
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign lerp_sum = (mul_p + 46'sd32768) >>> 16;
  assign lerp_val = {2'd0, lo} + lerp_sum[17:0];

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_PX:   px_r <= mul_p[29:0] + 30'd32768;
      OP_PY:   py_r <= mul_p[29:0] + 30'd32768;
      OP_ROW0: rb0  <= mul_p[25:0];
      OP_ROW1: rb1  <= mul_p[25:0];
      OP_TEX:  ta[cmd.sel] <= mul_p[28:0];
      OP_TOP:  top_r <= lerp_val[VAL_W-1:0];
      OP_BOT:  bot_r <= lerp_val[VAL_W-1:0];
      OP_FIN:  rgb[cmd.sel] <= lerp_val[VAL_W-1:0];
      default: ;
    endcase
  end

  // element store, single port
  logic [VAL_W-1:0]  mem [STORE_ELEMENTS];
  logic [29:0]       rd_addr;
  logic              rd_oob;
  logic              wr_ok;

  assign rd_addr = {1'b0, ta[cmd.rd_k]} + {28'd0, cmd.rd_ch};
  assign rd_oob  = (rd_addr >= 30'(STORE_ELEMENTS));
  assign wr_ok   = (32'(elem_addr) < 32'(STORE_ELEMENTS));

  always_ff @(posedge clk) begin
    if (cmd.mem_we && wr_ok) begin
      mem[MEM_AW'(elem_addr)] <= elem_value;
    end
    if (cmd.rd_en) begin
      tq[cmd.rd_k] <= rd_oob ? '0 : mem[MEM_AW'(rd_addr)];
    end
  end

  // result word
  logic out_valid;

  assign status.out_free = !out_valid || res.ready;
  assign res.valid       = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.out_red   <= rgb[0];
      res.out_green <= rgb[1];
      res.out_blue  <= rgb[2];
    end
  end

endmodule

>>> sv/bilinear_texture_sampler_core.sv
// Write word: one write per cycle while no sample word is in progress.
// Sample word: shared multiplier (4 setup and 4 address steps), then 12 reads from
// the single-port element store with lerps overlapping reads; the next word is
// taken only once the result word is loaded, which waits while the output is full.
// rst (synchronous) restores 64x64 texels, stride 3; store contents undefined.
module bilinear_texture_sampler_core (
  input  logic       clk,
  input  logic       rst,
  btex_req_if.sink   req,
  btex_res_if.source res,
  btex_cfg_if.sink   cfg
);
  import btex_pkg::*;

  cmd_t    cmd;
  status_t status;

  btex_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_type  (req.req_type),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  btex_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .elem_addr  (req.elem_addr),
    .elem_value (req.elem_value),
    .coord_u    (req.coord_u),
    .coord_v    (req.coord_v),
    .cfg        (cfg),
    .res        (res)
  );

endmodule

>>> verif/bilinear_texture_sampler_core_tb.sv
module bilinear_texture_sampler_core_tb;
  import btex_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES   = 400;
  localparam int WORDS_PER_SET = 50;

  typedef struct packed {
    logic [VAL_W-1:0] red;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] blue;
  } rgb_t;

  logic clk = 1'b0;
  logic rst;

  btex_req_if req_bus();
  btex_res_if res_bus();
  btex_cfg_if cfg_bus();

  bilinear_texture_sampler_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .res (res_bus),
    .cfg (cfg_bus)
  );

  always #10 clk = ~clk;

  // shadow of the texture registers and the element store
  logic [DIM_W-1:0]    tex_w = TEX_WIDTH_RST;
  logic [DIM_W-1:0]    tex_h = TEX_HEIGHT_RST;
  logic [STRIDE_W-1:0] tex_stride = STRIDE_RST;
  logic [VAL_W-1:0]    store_copy [STORE_ELEMENTS];
  bit                  store_written [STORE_ELEMENTS];

  rgb_t expected_rgb [$];
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_start = 1'b0;
  int   ready_hold = 0;

  function automatic logic [VAL_W-1:0] lerp_q16(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                                logic [63:0] wt);
    logic [63:0] acc;
    acc = (64'd65536 - wt) * a + wt * b + 64'd32768;
    return acc[31:16];
  endfunction

  function automatic void check_field(string tag, logic [VAL_W-1:0] want,
                                      logic [VAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, tag, want, got);
      errors++;
    end
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 16'h8000;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // result side: checks each word and drives ready
  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (expected_rgb.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h %h %h", $time,
                   res_bus.out_red, res_bus.out_green, res_bus.out_blue);
          errors++;
        end else begin
          want = expected_rgb.pop_front();
          check_field("out_red", want.red, res_bus.out_red);
          check_field("out_green", want.green, res_bus.out_green);
          check_field("out_blue", want.blue, res_bus.out_blue);
        end
      end
      if (hold_start)
        ready_hold = HOLD_CYCLES;
      if (ready_hold > 0) begin
        ready_hold--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_req(input logic req_type, input logic [ADDR_W-1:0] addr,
                          input logic [VAL_W-1:0] value, input logic [COORD_W-1:0] u,
                          input logic [COORD_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= req_type;
    req_bus.elem_addr  <= addr;
    req_bus.elem_value <= value;
    req_bus.coord_u    <= u;
    req_bus.coord_v    <= v;
    do @(posedge clk); while (!req_bus.ready);
    if (req_type == REQ_WRITE) begin
      store_copy[addr]    = value;
      store_written[addr] = 1'b1;
    end
  endtask

  // fills any unwritten texel in the footprint, then sends the sample word
  task automatic lookup_rgb(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
    logic [63:0]      w, h, px, py, x1, y1, wr, wb, c0, c1, r0, r1, row, col;
    logic [63:0]      addr [12];
    logic [VAL_W-1:0] texel [12];
    logic [VAL_W-1:0] top, bot;
    logic [VAL_W-1:0] mix [3];
    rgb_t             want;
    int               i;
    w  = (tex_w == 0) ? 64'd1 : 64'(tex_w);
    h  = (tex_h == 0) ? 64'd1 : 64'(tex_h);
    px = w * u;
    x1 = (px + 64'd32768) >> 16;
    wr = px + 64'd32768 - (x1 << 16);
    py = h * (64'd65536 - v);
    y1 = (py + 64'd32768) >> 16;
    wb = py + 64'd32768 - (y1 << 16);
    c0 = (x1 == 0) ? 64'd0 : ((x1 - 1 >= w) ? w - 1 : x1 - 1);
    c1 = (x1 >= w) ? w - 1 : x1;
    r0 = (y1 == 0) ? 64'd0 : ((y1 - 1 >= h) ? h - 1 : y1 - 1);
    r1 = (y1 >= h) ? h - 1 : y1;
    for (i = 0; i < 12; i++) begin
      row = i[1] ? r1 : r0;
      col = i[0] ? c1 : c0;
      addr[i] = (row * w + col) * tex_stride + 64'(i / 4);
      if (addr[i] < STORE_ELEMENTS && !store_written[addr[i][ADDR_W-1:0]])
        send_req(REQ_WRITE, addr[i][ADDR_W-1:0], VAL_W'($urandom), COORD_W'($urandom),
                 COORD_W'($urandom));
    end
    for (i = 0; i < 12; i++)
      texel[i] = (addr[i] < STORE_ELEMENTS) ? store_copy[addr[i][ADDR_W-1:0]] : '0;
    for (i = 0; i < 3; i++) begin
      top    = lerp_q16(texel[4*i], texel[4*i+1], wr);
      bot    = lerp_q16(texel[4*i+2], texel[4*i+3], wr);
      mix[i] = lerp_q16(top, bot, wb);
    end
    want.red   = mix[0];
    want.green = mix[1];
    want.blue  = mix[2];
    send_req(REQ_SAMPLE, ADDR_W'($urandom), VAL_W'($urandom), u, v);
    expected_rgb.push_back(want);
  endtask

  task automatic settle();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr  <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_TEX_WIDTH:  tex_w = data[DIM_W-1:0];
      CFG_TEX_HEIGHT: tex_h = data[DIM_W-1:0];
      CFG_STRIDE:     tex_stride = data[STRIDE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                          input logic [CFG_DATA_W-1:0] stride);
    settle();
    write_reg(CFG_TEX_WIDTH, w);
    write_reg(CFG_TEX_HEIGHT, h);
    write_reg(CFG_STRIDE, stride);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_defaults();
    send_req(REQ_WRITE, '1, '0, '0, '0);
    send_req(REQ_WRITE, '0, '1, '1, '1);
    lookup_rgb('0, '1);
    lookup_rgb('0, '0);
    lookup_rgb('1, '1);
    lookup_rgb(16'h8000, 16'h8000);
    lookup_rgb('1, '0);
  endtask

  task automatic test_edges();
    set_regs(13'd1, 13'd1, 13'd3);
    lookup_rgb('0, '0);
    lookup_rgb('1, '1);
    set_regs(13'd0, 13'd0, 13'd4);          // zero size treated as one texel
    lookup_rgb(16'h1234, 16'h8000);
    set_regs(13'd5, 13'd3, 13'd0);          // texels overlap
    lookup_rgb(16'h5A5A, 16'hA5A5);
    set_regs(13'd7, 13'd2, 13'h1FFF);       // stride field takes low bits only
    lookup_rgb('1, '0);
    set_regs(13'h1FFF, 13'h1FFF, 13'd7);    // taps of the first lookup beyond the store
    lookup_rgb('1, '0);
    lookup_rgb('0, '1);
    set_regs(13'd4096, 13'd4096, 13'd4);
    lookup_rgb(16'h8000, 16'h8000);
  endtask

  task automatic test_unused_index();
    set_regs(13'd9, 13'd6, 13'd3);
    write_reg(CFG_UNUSED, '1);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
    lookup_rgb(16'h8000, 16'h4000);
    lookup_rgb(16'hC000, 16'hF000);
  endtask

  task automatic test_random();
    logic [DIM_W-1:0]      w, h;
    logic [CFG_DATA_W-1:0] stride;
    int                    mode, set;
    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      for (set = 0; set < 4; set++) begin
        if ($urandom_range(0, 7) == 0) begin
          w = DIM_W'($urandom);
          h = DIM_W'($urandom);
        end else begin
          w = DIM_W'($urandom_range(1, 12));
          h = DIM_W'($urandom_range(1, 12));
        end
        stride = CFG_DATA_W'($urandom);
        if ($urandom_range(0, 3) != 0)
          stride[2:0] = 3'($urandom_range(3, 4));
        set_regs(w, h, stride);
        repeat (WORDS_PER_SET) begin
          if ($urandom_range(0, 3) == 0)
            send_req(REQ_WRITE, ADDR_W'($urandom), VAL_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom));
          else
            lookup_rgb(pick_coord(), pick_coord());
        end
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // result side held off while words keep coming, so the input backs up
  task automatic test_backpressure();
    set_regs(13'd6, 13'd5, 13'd4);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    repeat (30) lookup_rgb(COORD_W'($urandom), COORD_W'($urandom));
  endtask

  initial begin
    rst                = 1'b1;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = REQ_WRITE;
    req_bus.elem_addr  = '0;
    req_bus.elem_value = '0;
    req_bus.coord_u    = '0;
    req_bus.coord_v    = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.addr       = CFG_TEX_WIDTH;
    cfg_bus.data       = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_edges();
    test_unused_index();
    test_random();
    test_backpressure();
    settle();
    if (errors == 0)
      $display("bilinear_texture_sampler_core_tb: PASS");
    else
      $display("bilinear_texture_sampler_core_tb: FAIL");
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("%0t: timeout", $time);
    $display("bilinear_texture_sampler_core_tb: FAIL");
    $finish;
  end

endmodule

>>> sim.f
sv/btex_pkg.sv
sv/btex_req_if.sv
sv/btex_res_if.sv
sv/btex_cfg_if.sv
sv/btex_ctrl.sv
sv/btex_dp.sv
sv/bilinear_texture_sampler_core.sv
verif/bilinear_texture_sampler_core_tb.sv
